>>> design/lsisu_pkg.sv
// lsisu_pkg: shared types, codes and constants of the load/store step unit
// no dependencies; imported by every module of the block but lsisu_fifo
`default_nettype none

package lsisu_pkg;

  // default size of the byte stack
  localparam int unsigned StackBytesDef = 4096;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_STACK_BASE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INITIAL_SP = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PROG_LEN   = 2'd2;

  // instruction kinds
  localparam logic [3:0] K_NOP  = 4'd0;
  localparam logic [3:0] K_MOV  = 4'd1;
  localparam logic [3:0] K_ADD  = 4'd2;
  localparam logic [3:0] K_SUB  = 4'd3;
  localparam logic [3:0] K_AND  = 4'd4;
  localparam logic [3:0] K_EOR  = 4'd5;
  localparam logic [3:0] K_MUL  = 4'd6;
  localparam logic [3:0] K_CMP  = 4'd7;
  localparam logic [3:0] K_LDR  = 4'd8;
  localparam logic [3:0] K_LDRB = 4'd9;
  localparam logic [3:0] K_STR  = 4'd10;
  localparam logic [3:0] K_STRB = 4'd11;
  localparam logic [3:0] K_B    = 4'd12;
  localparam logic [3:0] K_BGT  = 4'd13;
  localparam logic [3:0] K_BLE  = 4'd14;
  localparam logic [3:0] K_RET  = 4'd15;

  // result status codes
  localparam logic [2:0] ST_RUNNING = 3'd0;
  localparam logic [2:0] ST_END     = 3'd1;
  localparam logic [2:0] ST_RETURN  = 3'd2;
  localparam logic [2:0] ST_FAULT   = 3'd3;
  localparam logic [2:0] ST_BAD_PC  = 3'd4;

  // register numbers with a special meaning
  localparam logic [5:0] REG_ZERO = 6'd31;
  localparam logic [5:0] REG_SP   = 6'd32;

  typedef struct packed {
    logic [3:0]  kind;
    logic [5:0]  dest_reg;
    logic        dest_narrow;
    logic [5:0]  src1_reg;
    logic        src1_narrow;
    logic [5:0]  src2_reg;
    logic        src2_narrow;
    logic        use_immediate;
    logic [63:0] immediate;
    logic [5:0]  index_shift;
  } item_t;

  // classification done by the front end
  typedef struct packed {
    logic       is_mem;
    logic       is_load;
    logic       is_mul;
    logic       writes;
    logic [3:0] nbytes;
  } cls_t;

  typedef struct packed {
    item_t item;
    cls_t  cls;
  } entry_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] next_pc;
    logic        reg_write;
    logic [5:0]  reg_index;
    logic [63:0] reg_value;
    logic [3:0]  flags_nzcv;
  } res_t;

endpackage

`default_nettype wire

>>> design/lsisu_fifo.sv
// lsisu_fifo: small register queue used between the block's parts
// no dependencies
`default_nettype none

module lsisu_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wp_q, rp_q;
  logic [PtrW:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rp_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= (wp_q == PtrW'(Depth-1)) ? '0 : wp_q + 1'b1;
      end
      if (do_pop) begin
        rp_q <= (rp_q == PtrW'(Depth-1)) ? '0 : rp_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // beat storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> design/lsisu_front.sv
// lsisu_front: classifies incoming instructions and queues them for the back end
// depends on lsisu_pkg and lsisu_fifo
`default_nettype none

module lsisu_front
  import lsisu_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire item_t  item_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output entry_t      ent_o,
  output logic        empty_o
);

  entry_t ent_in;

  // decode the kind into execution classes
  always_comb begin
    ent_in.item        = item_i;
    ent_in.cls.is_mem  = (item_i.kind == K_LDR) || (item_i.kind == K_LDRB) ||
                         (item_i.kind == K_STR) || (item_i.kind == K_STRB);
    ent_in.cls.is_load = (item_i.kind == K_LDR) || (item_i.kind == K_LDRB);
    ent_in.cls.is_mul  = (item_i.kind == K_MUL);
    ent_in.cls.writes  = (item_i.kind == K_MOV) || (item_i.kind == K_ADD) ||
                         (item_i.kind == K_SUB) || (item_i.kind == K_AND) ||
                         (item_i.kind == K_EOR) || (item_i.kind == K_MUL) ||
                         (item_i.kind == K_LDR) || (item_i.kind == K_LDRB);
    if ((item_i.kind == K_LDRB) || (item_i.kind == K_STRB)) begin
      ent_in.cls.nbytes = 4'd1;
    end else if (item_i.dest_narrow) begin
      ent_in.cls.nbytes = 4'd4;
    end else begin
      ent_in.cls.nbytes = 4'd8;
    end
  end

  lsisu_fifo #(
    .Width($bits(entry_t)),
    .Depth(2)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (ent_in),
    .full_o (full_o),
    .pop_i  (pop_i),
    .data_o (ent_o),
    .empty_o(empty_o)
  );

endmodule

`default_nettype wire

>>> design/lsisu_back.sv
// lsisu_back: execution sequencer with register file, shared multiplier and byte stack
// depends on lsisu_pkg
`default_nettype none

module lsisu_back
  import lsisu_pkg::*;
#(
  parameter int unsigned StackBytes = StackBytesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [63:0]        cfg_wdata_i,
  input  wire entry_t             ent_i,
  input  wire logic               ent_empty_i,
  output logic                    ent_pop_o,
  output res_t                    res_o,
  output logic                    res_push_o,
  input  wire logic               res_full_i
);

  localparam int unsigned AW = $clog2(StackBytes);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RDA  = 4'd2;
  localparam logic [3:0] S_RDB  = 4'd3;
  localparam logic [3:0] S_RDD  = 4'd4;
  localparam logic [3:0] S_EXEC = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_ADDR = 4'd7;
  localparam logic [3:0] S_CHK  = 4'd8;
  localparam logic [3:0] S_MEM  = 4'd9;
  localparam logic [3:0] S_MEMR = 4'd10;
  localparam logic [3:0] S_WB   = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  function automatic logic [63:0] nar(input logic [5:0] idx, input logic n,
                                      input logic [63:0] v);
    logic [63:0] r;
    r = v;
    if ((idx < REG_ZERO) && n) begin
      r = {32'd0, v[31:0]};
    end
    return r;
  endfunction

  logic [3:0]    state_q;
  entry_t        cur_q;
  logic [63:0]   opa_q, opb_q, opd_q;
  logic [63:0]   sp_q, pc_q, base_q, val_q, npc_q, addr_q, mp_q;
  logic [15:0]   plen_q;
  logic [3:0]    flags_q;
  logic [64:0]   diff_q;
  logic [AW-1:0] off_q, clr_q;
  logic [2:0]    bcnt_q;
  logic [1:0]    mcnt_q;
  res_t          res_q;

  // register file storage and read port
  logic [63:0] rf_mem [31];
  logic [30:0] rf_vld_q;
  logic [63:0] rf_rd_q;
  logic        rf_rd_vld_q;
  logic [5:0]  rd_idx, rd_idx_q;
  logic [4:0]  rf_raddr, rf_waddr;
  logic        rf_we;
  logic [63:0] rf_val;

  // stack storage port
  logic [7:0]    stk_mem [StackBytes];
  logic [7:0]    mem_rd_q;
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [7:0]    mem_wd;

  item_t         it;
  logic          start;
  logic [63:0]   end_w, a_w, b_w, idx_w, alu_w, am, bm, cr, wv;
  logic [3:0]    cmp_flags;
  logic          early, br_take, fault, last_b, wr_ok;
  logic [2:0]    early_st;
  logic [31:0]   mx, my;
  logic [63:0]   limit;

  assign it    = cur_q.item;
  assign start = (state_q == S_IDLE) && !ent_empty_i && !res_full_i;
  assign ent_pop_o  = start;
  assign res_push_o = (state_q == S_OUT);
  assign res_o      = res_q;
  assign end_w      = {46'd0, plen_q, 2'b00};

  // register read address sequence: base, second source, transfer register
  always_comb begin
    unique case (state_q)
      S_IDLE:  rd_idx = ent_i.item.src1_reg;
      S_RDA:   rd_idx = it.src2_reg;
      S_RDB:   rd_idx = it.dest_reg;
      default: rd_idx = '0;
    endcase
    rf_raddr = (rd_idx < REG_ZERO) ? rd_idx[4:0] : 5'd0;
    rf_waddr = (it.dest_reg < REG_ZERO) ? it.dest_reg[4:0] : 5'd0;
    if (rd_idx_q < REG_ZERO) begin
      rf_val = rf_rd_vld_q ? rf_rd_q : 64'd0;
    end else if (rd_idx_q == REG_SP) begin
      rf_val = sp_q;
    end else begin
      rf_val = 64'd0;
    end
  end

  // write-back value
  assign wr_ok = cur_q.cls.writes && ((it.dest_reg < REG_ZERO) || (it.dest_reg == REG_SP));
  assign wv    = nar(it.dest_reg, it.dest_narrow, val_q);
  assign rf_we = (state_q == S_WB) && wr_ok && (it.dest_reg < REG_ZERO);

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[rf_waddr] <= wv;
    end
    rf_rd_q <= rf_mem[rf_raddr];
  end

  // operand shaping, combinational arithmetic, compare flags, branch and early-exit decisions
  always_comb begin
    a_w   = nar(it.src1_reg, it.src1_narrow, opa_q);
    idx_w = nar(it.src2_reg, it.src2_narrow, opb_q);
    b_w   = it.use_immediate ? it.immediate : idx_w;
    am    = it.src1_narrow ? {32'd0, a_w[31:0]} : a_w;
    bm    = it.src1_narrow ? {32'd0, b_w[31:0]} : b_w;
    cr    = am - bm;
    if (it.src1_narrow) begin
      cr = {32'd0, cr[31:0]};
      cmp_flags = {cr[31], (cr == 64'd0), (am >= bm), ((am[31] ^ bm[31]) & (am[31] ^ cr[31]))};
    end else begin
      cmp_flags = {cr[63], (cr == 64'd0), (am >= bm), ((am[63] ^ bm[63]) & (am[63] ^ cr[63]))};
    end
    unique case (it.kind)
      K_MOV:   alu_w = it.use_immediate ? it.immediate : a_w;
      K_ADD:   alu_w = a_w + b_w;
      K_SUB:   alu_w = a_w - b_w;
      K_AND:   alu_w = a_w & b_w;
      K_EOR:   alu_w = a_w ^ b_w;
      default: alu_w = 64'd0;
    endcase
    unique case (it.kind)
      K_B:     br_take = 1'b1;
      K_BGT:   br_take = !flags_q[2] && (flags_q[3] == flags_q[0]);
      K_BLE:   br_take = flags_q[2] || (flags_q[3] != flags_q[0]);
      default: br_take = 1'b0;
    endcase
    priority if (pc_q == end_w) begin
      early = 1'b1;
      early_st = ST_END;
    end else if ((pc_q[1:0] != 2'b00) || (pc_q > end_w)) begin
      early = 1'b1;
      early_st = ST_BAD_PC;
    end else if (it.kind == K_RET) begin
      early = 1'b1;
      early_st = ST_RETURN;
    end else begin
      early = 1'b0;
      early_st = ST_RUNNING;
    end
  end

  // shared 32x32 multiplier operand select
  always_comb begin
    unique case (mcnt_q)
      2'd0:    begin mx = opa_q[31:0];  my = opb_q[31:0];  end
      2'd1:    begin mx = opa_q[31:0];  my = opb_q[63:32]; end
      2'd2:    begin mx = opa_q[63:32]; my = opb_q[31:0];  end
      default: begin mx = 32'd0;        my = 32'd0;        end
    endcase
  end

  // bounds check against the stack window
  assign limit  = 64'(StackBytes) - {60'd0, cur_q.cls.nbytes};
  assign fault  = diff_q[64] || (diff_q[63:0] > limit);
  assign last_b = ({1'b0, bcnt_q} + 4'd1) == cur_q.cls.nbytes;

  // stack port: clearing sweep or byte access
  always_comb begin
    if (state_q == S_CLR) begin
      mem_addr = clr_q;
      mem_we   = 1'b1;
      mem_wd   = 8'd0;
    end else begin
      mem_addr = off_q + AW'(bcnt_q);
      mem_we   = (state_q == S_MEM) && !cur_q.cls.is_load;
      mem_wd   = 8'(val_q >> {bcnt_q, 3'b000});
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stk_mem[mem_addr] <= mem_wd;
    end
    mem_rd_q <= stk_mem[mem_addr];
  end

  // architectural state and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      rf_vld_q    <= '0;
      rf_rd_vld_q <= 1'b0;
      rd_idx_q    <= '0;
      sp_q        <= '0;
      pc_q        <= '0;
      flags_q     <= '0;
      base_q      <= '0;
      plen_q      <= '0;
    end else begin
      rf_rd_vld_q <= rf_vld_q[rf_raddr];
      rd_idx_q    <= rd_idx;
      if (rf_we) begin
        rf_vld_q[rf_waddr] <= 1'b1;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_STACK_BASE: base_q <= cfg_wdata_i;
          CFG_INITIAL_SP: sp_q   <= cfg_wdata_i;
          CFG_PROG_LEN:   plen_q <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(StackBytes-1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            state_q <= S_RDA;
          end
        end
        S_RDA:  state_q <= S_RDB;
        S_RDB:  state_q <= S_RDD;
        S_RDD:  state_q <= S_EXEC;
        S_EXEC: begin
          if (early) begin
            state_q <= S_OUT;
          end else if (cur_q.cls.is_mem) begin
            state_q <= S_ADDR;
          end else if (cur_q.cls.is_mul) begin
            state_q <= S_MUL;
          end else begin
            if (it.kind == K_CMP) begin
              flags_q <= cmp_flags;
            end
            state_q <= S_WB;
          end
        end
        S_MUL: begin
          if (mcnt_q == 2'd3) begin
            state_q <= S_WB;
          end
        end
        S_ADDR: state_q <= S_CHK;
        S_CHK:  state_q <= fault ? S_OUT : S_MEM;
        S_MEM: begin
          if (cur_q.cls.is_load) begin
            state_q <= S_MEMR;
          end else if (last_b) begin
            state_q <= S_WB;
          end
        end
        S_MEMR: state_q <= last_b ? S_WB : S_MEM;
        S_WB: begin
          if (wr_ok && (it.dest_reg == REG_SP)) begin
            sp_q <= wv;
          end
          pc_q    <= npc_q;
          state_q <= S_OUT;
        end
        S_OUT:   state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cur_q <= ent_i;
        end
      end
      S_RDA: opa_q <= rf_val;
      S_RDB: opb_q <= rf_val;
      S_RDD: opd_q <= rf_val;
      S_EXEC: begin
        npc_q  <= br_take ? it.immediate : pc_q + 64'd4;
        addr_q <= opa_q + (it.use_immediate ? it.immediate : (idx_w << it.index_shift));
        opa_q  <= a_w;
        opb_q  <= b_w;
        val_q  <= alu_w;
        mcnt_q <= 2'd0;
        res_q  <= '{status: early_st, next_pc: pc_q, reg_write: 1'b0,
                    reg_index: 6'd0, reg_value: 64'd0, flags_nzcv: flags_q};
      end
      S_MUL: begin
        mp_q   <= mx * my;
        mcnt_q <= mcnt_q + 2'd1;
        if (mcnt_q == 2'd1) begin
          val_q <= mp_q;
        end else if (mcnt_q != 2'd0) begin
          val_q[63:32] <= val_q[63:32] + mp_q[31:0];
        end
      end
      S_ADDR: diff_q <= {1'b0, addr_q} - {1'b0, base_q};
      S_CHK: begin
        off_q  <= diff_q[AW-1:0];
        bcnt_q <= 3'd0;
        val_q  <= cur_q.cls.is_load ? 64'd0 : nar(it.dest_reg, it.dest_narrow, opd_q);
        res_q  <= '{status: ST_FAULT, next_pc: pc_q, reg_write: 1'b0,
                    reg_index: 6'd0, reg_value: 64'd0, flags_nzcv: flags_q};
      end
      S_MEM: begin
        if (!cur_q.cls.is_load && !last_b) begin
          bcnt_q <= bcnt_q + 3'd1;
        end
      end
      S_MEMR: begin
        val_q <= val_q | ({56'd0, mem_rd_q} << {bcnt_q, 3'b000});
        if (!last_b) begin
          bcnt_q <= bcnt_q + 3'd1;
        end
      end
      S_WB: begin
        res_q <= '{status: (npc_q == end_w) ? ST_END : ST_RUNNING, next_pc: npc_q,
                   reg_write: wr_ok, reg_index: wr_ok ? it.dest_reg : 6'd0,
                   reg_value: wr_ok ? wv : 64'd0, flags_nzcv: flags_q};
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> design/load_store_isa_step_unit.sv
// load/store step unit: one decoded instruction per input beat, one result beat each
// steps: read base, second source, transfer register; execute; multiply, or address, bounds
// check and byte access; write-back; result out (end, bad pc, return and faults go there early)
// throughput: one instruction at a time, started only when an entry waits and the result queue has room
// reset: registers, flags and pc clear; the stack is swept to zero before the first instruction
// depends on lsisu_pkg, lsisu_fifo, lsisu_front, lsisu_back
`default_nettype none

module load_store_isa_step_unit
  import lsisu_pkg::*;
#(
  parameter int unsigned StackBytes = StackBytesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [63:0]        cfg_wdata_i,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [3:0]         kind_i,
  input  wire logic [5:0]         dest_reg_i,
  input  wire logic               dest_narrow_i,
  input  wire logic [5:0]         src1_reg_i,
  input  wire logic               src1_narrow_i,
  input  wire logic [5:0]         src2_reg_i,
  input  wire logic               src2_narrow_i,
  input  wire logic               use_immediate_i,
  input  wire logic [63:0]        immediate_i,
  input  wire logic [5:0]         index_shift_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic [2:0]              status_o,
  output logic [63:0]             next_pc_o,
  output logic                    reg_write_o,
  output logic [5:0]              reg_index_o,
  output logic [63:0]             reg_value_o,
  output logic [3:0]              flags_nzcv_o
);

  item_t  item;
  entry_t ent;
  logic   ent_empty, ent_pop;
  res_t   res_in, res_out;
  logic   res_push, res_full;

  // pack the input beat
  assign item = '{kind: kind_i, dest_reg: dest_reg_i, dest_narrow: dest_narrow_i,
                  src1_reg: src1_reg_i, src1_narrow: src1_narrow_i,
                  src2_reg: src2_reg_i, src2_narrow: src2_narrow_i,
                  use_immediate: use_immediate_i, immediate: immediate_i,
                  index_shift: index_shift_i};

  lsisu_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (item),
    .full_o (full),
    .pop_i  (ent_pop),
    .ent_o  (ent),
    .empty_o(ent_empty)
  );

  lsisu_back #(
    .StackBytes(StackBytes)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .ent_i      (ent),
    .ent_empty_i(ent_empty),
    .ent_pop_o  (ent_pop),
    .res_o      (res_in),
    .res_push_o (res_push),
    .res_full_i (res_full)
  );

  // result queue toward the consumer
  lsisu_fifo #(
    .Width($bits(res_t)),
    .Depth(2)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_out),
    .empty_o(empty)
  );

  assign status_o     = res_out.status;
  assign next_pc_o    = res_out.next_pc;
  assign reg_write_o  = res_out.reg_write;
  assign reg_index_o  = res_out.reg_index;
  assign reg_value_o  = res_out.reg_value;
  assign flags_nzcv_o = res_out.flags_nzcv;

endmodule

`default_nettype wire

>>> design/lsisu_chk.sv
// lsisu_chk: port-level checks on the result side of the step unit
// depends on lsisu_pkg; bound to load_store_isa_step_unit
`default_nettype none

module lsisu_chk
  import lsisu_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [2:0]  status_o,
  input wire logic        reg_write_o,
  input wire logic [5:0]  reg_index_o,
  input wire logic [63:0] reg_value_o
);

  // status is one of the defined codes
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (status_o == ST_RUNNING || status_o == ST_END || status_o == ST_RETURN ||
                status_o == ST_FAULT || status_o == ST_BAD_PC))
    else $error("status code out of range");

  // no register write reports zero index and value
  a_nowrite_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !reg_write_o) |-> (reg_index_o == 6'd0 && reg_value_o == 64'd0))
    else $error("index or value set without a register write");

  // only real registers are reported written
  a_write_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && reg_write_o) |-> (reg_index_o < REG_ZERO || reg_index_o == REG_SP))
    else $error("write reported to zero register or unknown register");

  // a beat not taken stays
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(status_o) && $stable(reg_value_o)))
    else $error("result beat changed before pop");

endmodule

bind load_store_isa_step_unit lsisu_chk u_lsisu_chk (.*);

`default_nettype wire
